[rtl/rnea_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnea_pkg: shared types and constants for the ring neighbor exclusion arbiter
// Seat limits, request/status codes and the structs passed between stages.
// ----------------------------------------------------------------------------
package rnea_pkg;

    localparam int MAX_SEATS = 32;
    localparam int SEAT_W    = $clog2(MAX_SEATS);
    localparam int CNT_W     = $clog2(MAX_SEATS + 1);
    localparam int TYPE_W    = 2;
    localparam int STATUS_W  = 2;

    localparam logic [CNT_W-1:0] SEAT_COUNT_RESET = CNT_W'(5);

    // request codes
    localparam logic [TYPE_W-1:0] REQ_ACQUIRE = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_RELEASE = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_END     = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ENDED = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd2;

    typedef struct packed {
        logic [TYPE_W-1:0] req_type;
        logic [SEAT_W-1:0] seat;
    } rnea_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0]  status;
        logic                 requester_eating;
        logic [MAX_SEATS-1:0] grant_mask;
        logic [MAX_SEATS-1:0] cancelled_mask;
    } rnea_result_t;

    typedef struct packed {
        logic [MAX_SEATS-1:0] hungry;
        logic [MAX_SEATS-1:0] eating;
        logic                 ended;
    } rnea_state_t;

endpackage
`default_nettype wire

[rtl/rnea_if.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnea interfaces: request, response and configuration channels
// Valid/ready channels; a transaction completes when both are high.
// ----------------------------------------------------------------------------
interface rnea_req_if import rnea_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TYPE_W-1:0] req_type;
    logic [SEAT_W-1:0] seat;

    modport source (output valid, output req_type, output seat, input ready);
    modport sink   (input valid, input req_type, input seat, output ready);
endinterface

interface rnea_rsp_if import rnea_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [STATUS_W-1:0]  status;
    logic                 requester_eating;
    logic [MAX_SEATS-1:0] grant_mask;
    logic [MAX_SEATS-1:0] cancelled_mask;

    modport source (output valid, output status, output requester_eating,
                    output grant_mask, output cancelled_mask, input ready);
    modport sink   (input valid, input status, input requester_eating,
                    input grant_mask, input cancelled_mask, output ready);
endinterface

interface rnea_cfg_if import rnea_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CNT_W-1:0] seat_count;

    modport source (output valid, output seat_count, input ready);
    modport sink   (input valid, input seat_count, output ready);
endinterface
`default_nettype wire

[rtl/rnea_in_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnea_in_stage: request input register
// Holds one request transaction until the core commits it.
// ----------------------------------------------------------------------------
module rnea_in_stage import rnea_pkg::*; (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       req_valid,
    input  wire rnea_item_t req_item,
    output logic            req_ready,
    input  wire logic       advance,
    output logic            item_valid,
    output rnea_item_t      item
);

    logic       valid_reg;
    logic       valid_next;
    rnea_item_t item_reg;

    assign req_ready  = !valid_reg || advance;
    assign valid_next = req_ready ? req_valid : valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_ready && req_valid)
        begin
            item_reg <= req_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule
`default_nettype wire

[rtl/rnea_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnea_core: seat state and single-pass arbitration logic
// Per-seat hungry/eating flags; each seat tests its ring neighbors in parallel.
// ----------------------------------------------------------------------------
module rnea_core import rnea_pkg::*; (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CNT_W-1:0] seat_count,
    input  wire rnea_item_t       item,
    input  wire logic             commit,
    output rnea_result_t          result,
    output rnea_state_t           state_view
);

    logic [MAX_SEATS-1:0] hungry_reg, hungry_next;
    logic [MAX_SEATS-1:0] eating_reg, eating_next;
    logic                 ended_reg, ended_next;

    logic [CNT_W-1:0]     ring_n;
    logic [SEAT_W-1:0]    last_seat;
    logic [SEAT_W-1:0]    left_seat;
    logic [SEAT_W-1:0]    right_seat;
    logic                 in_ring;
    logic                 small_ring;
    logic                 rel_ok;
    logic [MAX_SEATS-1:0] seat_oh, left_oh, right_oh;
    logic [MAX_SEATS-1:0] eat_view, left_eat, right_eat, free_mask, cand;
    logic [MAX_SEATS-1:0] grant_l, grant_r;

    // clamp count to 1..MAX_SEATS
    always_comb
    begin
        if (seat_count == '0)
        begin
            ring_n = CNT_W'(1);
        end
        else if (seat_count > CNT_W'(MAX_SEATS))
        begin
            ring_n = CNT_W'(MAX_SEATS);
        end
        else
        begin
            ring_n = seat_count;
        end
    end

    assign last_seat  = SEAT_W'(ring_n - CNT_W'(1));
    assign in_ring    = CNT_W'(item.seat) < ring_n;
    assign small_ring = ring_n <= CNT_W'(3);
    assign left_seat  = (item.seat == '0) ? last_seat : item.seat - SEAT_W'(1);
    assign right_seat = (item.seat == last_seat) ? '0 : item.seat + SEAT_W'(1);
    assign seat_oh    = MAX_SEATS'(1) << item.seat;
    assign left_oh    = MAX_SEATS'(1) << left_seat;
    assign right_oh   = MAX_SEATS'(1) << right_seat;

    assign rel_ok   = (item.req_type == REQ_RELEASE) && in_ring && eating_reg[item.seat];
    // eating view with the releasing seat already dropped
    assign eat_view = rel_ok ? (eating_reg & ~seat_oh) : eating_reg;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SEATS; gi++)
        begin : g_seat
            localparam int NEXT = (gi == MAX_SEATS - 1) ? 0 : gi + 1;
            if (gi == 0)
            begin : g_first
                assign left_eat[gi] = eat_view[last_seat];
            end
            else
            begin : g_rest
                assign left_eat[gi] = eat_view[gi - 1];
            end
            assign right_eat[gi] = (SEAT_W'(gi) == last_seat) ? eat_view[0]
                                                               : eat_view[NEXT];
        end
    endgenerate

    assign free_mask = ~(left_eat | right_eat);
    assign cand      = hungry_reg & free_mask;
    assign grant_l   = cand & left_oh;
    // in a ring of three or fewer the two neighbors touch: left grant blocks right
    assign grant_r   = cand & right_oh & ~{MAX_SEATS{(|grant_l) && small_ring}};

    always_comb
    begin
        result.status           = STATUS_OK;
        result.requester_eating = 1'b0;
        result.grant_mask       = '0;
        result.cancelled_mask   = '0;
        hungry_next             = hungry_reg;
        eating_next             = eating_reg;
        ended_next              = ended_reg;
        case (item.req_type)
            REQ_ACQUIRE:
            begin
                if (ended_reg)
                begin
                    result.status = STATUS_ENDED;
                end
                else if (!in_ring || hungry_reg[item.seat] || eating_reg[item.seat])
                begin
                    result.status = STATUS_BAD;
                end
                else if (free_mask[item.seat])
                begin
                    eating_next             = eating_reg | seat_oh;
                    result.requester_eating = 1'b1;
                    result.grant_mask       = seat_oh;
                end
                else
                begin
                    hungry_next = hungry_reg | seat_oh;
                end
            end
            REQ_RELEASE:
            begin
                if (!rel_ok)
                begin
                    result.status = STATUS_BAD;
                end
                else
                begin
                    eating_next       = eat_view | grant_l | grant_r;
                    hungry_next       = hungry_reg & ~(grant_l | grant_r);
                    result.grant_mask = grant_l | grant_r;
                end
            end
            REQ_END:
            begin
                if (ended_reg)
                begin
                    result.status = STATUS_ENDED;
                end
                else
                begin
                    ended_next            = 1'b1;
                    hungry_next           = '0;
                    result.cancelled_mask = hungry_reg;
                end
            end
            default:
            begin
                result.status = STATUS_BAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hungry_reg <= '0;
            eating_reg <= '0;
            ended_reg  <= 1'b0;
        end
        else if (commit)
        begin
            hungry_reg <= hungry_next;
            eating_reg <= eating_next;
            ended_reg  <= ended_next;
        end
    end

    assign state_view.hungry = hungry_reg;
    assign state_view.eating = eating_reg;
    assign state_view.ended  = ended_reg;

endmodule
`default_nettype wire

[rtl/rnea_out_stage.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rnea_out_stage: result register
// Holds one response transaction until the sink takes it.
// ----------------------------------------------------------------------------
module rnea_out_stage import rnea_pkg::*; (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         load,
    input  wire rnea_result_t result_in,
    output logic              room,
    output logic              rsp_valid,
    input  wire logic         rsp_ready,
    output rnea_result_t      result_out
);

    logic         valid_reg;
    logic         valid_next;
    rnea_result_t result_reg;

    assign room       = !valid_reg || rsp_ready;
    assign valid_next = load || (valid_reg && !rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

    assign rsp_valid  = valid_reg;
    assign result_out = result_reg;

endmodule
`default_nettype wire

[rtl/ring_neighbor_exclusion_arbiter_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ring_neighbor_exclusion_arbiter_unit: ring seat arbiter top level
// Grants seats in a ring so that no two neighbors eat at once.
// ----------------------------------------------------------------------------
// Each request transaction (acquire, release or end of session) yields
// exactly one response transaction. A transaction is registered on entry,
// decided combinationally against the per-seat hungry/eating flags (every
// seat checks its two ring neighbors in parallel, with wrap at the
// configured count), and the result is registered on exit. One transaction
// can be taken every cycle while the sink takes responses, the seat-state
// update of one transaction being visible to the next. The response register
// decouples the sides, so a new request is still taken while a finished
// response waits, until both registers are full. seat_count (reset 5) sets
// the ring size; 0 acts as 1 and values above 32 act as 32. Write it only
// while no transaction is in flight; the config channel is always ready.
// ----------------------------------------------------------------------------
module ring_neighbor_exclusion_arbiter_unit import rnea_pkg::*; (
    input  wire logic clk,
    input  wire logic rst_n,
    rnea_req_if.sink   req,
    rnea_rsp_if.source rsp,
    rnea_cfg_if.sink   cfg
);

    logic [CNT_W-1:0] seat_count_reg;
    logic [CNT_W-1:0] seat_count_next;

    rnea_item_t   req_item;
    rnea_item_t   item;
    logic         item_valid;
    logic         room;
    logic         advance;
    rnea_result_t core_result;
    rnea_result_t out_result;
    rnea_state_t  state_view;

    // configuration register: always ready
    assign cfg.ready       = 1'b1;
    assign seat_count_next = cfg.valid ? cfg.seat_count : seat_count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seat_count_reg <= SEAT_COUNT_RESET;
        end
        else
        begin
            seat_count_reg <= seat_count_next;
        end
    end

    assign req_item.req_type = req.req_type;
    assign req_item.seat     = req.seat;

    // commit state and load the response in the same edge
    assign advance = item_valid && room;

    rnea_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req.valid),
        .req_item   (req_item),
        .req_ready  (req.ready),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    rnea_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .seat_count (seat_count_reg),
        .item       (item),
        .commit     (advance),
        .result     (core_result),
        .state_view (state_view)
    );

    rnea_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (advance),
        .result_in  (core_result),
        .room       (room),
        .rsp_valid  (rsp.valid),
        .rsp_ready  (rsp.ready),
        .result_out (out_result)
    );

    assign rsp.status           = out_result.status;
    assign rsp.requester_eating = out_result.requester_eating;
    assign rsp.grant_mask       = out_result.grant_mask;
    assign rsp.cancelled_mask   = out_result.cancelled_mask;

    // a seat is never hungry and eating at once
    a_flags_disjoint: assert property (@(posedge clk) disable iff (!rst_n)
        (state_view.hungry & state_view.eating) == '0)
        else $error("seat both hungry and eating");

    // once the session ends no seat may wait
    a_no_hungry_after_end: assert property (@(posedge clk) disable iff (!rst_n)
        state_view.ended |-> (state_view.hungry == '0))
        else $error("hungry seat after end of session");

    // rejected transactions change nothing
    a_reject_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && (rsp.status != STATUS_OK)) |->
        (!rsp.requester_eating && (rsp.grant_mask == '0) && (rsp.cancelled_mask == '0)))
        else $error("rejected transaction reports grants or cancels");

    // an immediate grant names exactly one seat
    a_self_grant_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.requester_eating) |-> $onehot(rsp.grant_mask))
        else $error("immediate grant not one-hot");

endmodule
`default_nettype wire

[bench/tb_ring_neighbor_exclusion_arbiter_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ring_neighbor_exclusion_arbiter_unit: self-checking bench for the arbiter
// Drives acquire/release/end transactions with random gaps and back-pressure,
// predicts every response from a seat-state shadow and compares field-wise.
// ----------------------------------------------------------------------------
module tb_ring_neighbor_exclusion_arbiter_unit import rnea_pkg::*; ();

    // req_type 3 has no meaning; the block must flag it as bad
    localparam logic [TYPE_W-1:0] REQ_ILLEGAL = 2'd3;

    // cycles without any transaction before the run is declared hung
    localparam int unsigned HANG_LIMIT = 2000;
    localparam int unsigned PHASE_ITEMS = 220;

    typedef enum logic [1:0] {
        SEAT_THINKING = 2'd0,
        SEAT_HUNGRY   = 2'd1,
        SEAT_EATING   = 2'd2
    } seat_mode_t;

    logic clk;
    logic rst_n;

    rnea_req_if req_ch ();
    rnea_rsp_if rsp_ch ();
    rnea_cfg_if cfg_ch ();

    ring_neighbor_exclusion_arbiter_unit u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // ------------------------------------------------------------------
    // Clock: 10 ns period
    // ------------------------------------------------------------------
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------
    rnea_item_t   req_backlog [$];     // requests waiting for the driver
    rnea_result_t predicted_rsp_q [$]; // responses owed by the block, oldest first

    // shadow of the arbiter: per-seat mode, session flag, ring size register
    seat_mode_t       seat_mode [MAX_SEATS];
    logic             session_over;
    logic [CNT_W-1:0] seat_count_cfg;

    int unsigned items_queued;
    int unsigned results_seen;
    int unsigned mismatches;
    int unsigned quiet_cycles;

    // idle shaping: each side flips between gappy and back-to-back now and then
    int unsigned req_gap;
    bit          req_burst;
    int unsigned rsp_hold;
    bit          rsp_burst;

    // ------------------------------------------------------------------
    // Seat-state predictor
    // ------------------------------------------------------------------

    // effective ring size: 0 behaves as 1, anything above MAX_SEATS as MAX_SEATS
    function automatic int unsigned ring_len();
        if (seat_count_cfg == 0)
            return 1;
        if (seat_count_cfg > MAX_SEATS)
            return MAX_SEATS;
        return seat_count_cfg;
    endfunction

    function automatic int unsigned ring_left(input int unsigned s, input int unsigned n);
        return (s == 0) ? n - 1 : s - 1;
    endfunction

    function automatic int unsigned ring_right(input int unsigned s, input int unsigned n);
        return (s + 1 >= n) ? 0 : s + 1;
    endfunction

    // a hungry seat with no eating neighbor starts eating; returns its grant bit
    function automatic logic [MAX_SEATS-1:0] grant_if_clear(input int unsigned s,
                                                            input int unsigned n);
        logic [MAX_SEATS-1:0] bit_out;
        bit_out = '0;
        if (seat_mode[s] == SEAT_HUNGRY && seat_mode[ring_left(s, n)] != SEAT_EATING
            && seat_mode[ring_right(s, n)] != SEAT_EATING)
        begin
            seat_mode[s] = SEAT_EATING;
            bit_out[s]   = 1'b1;
        end
        return bit_out;
    endfunction

    // applies one request to the shadow and returns the response it owes
    function automatic rnea_result_t arbitrate(input rnea_item_t it);
        rnea_result_t res;
        int unsigned  n;
        int unsigned  s;
        res        = '0;
        res.status = STATUS_OK;
        n          = ring_len();
        s          = it.seat;
        case (it.req_type)
            REQ_ACQUIRE:
            begin
                if (session_over)
                    res.status = STATUS_ENDED;
                else if (s >= n || seat_mode[s] != SEAT_THINKING)
                    res.status = STATUS_BAD;
                else
                begin
                    seat_mode[s]         = SEAT_HUNGRY;
                    res.grant_mask       = grant_if_clear(s, n);
                    res.requester_eating = |res.grant_mask;
                end
            end
            REQ_RELEASE:
            begin
                // releases still work after the end; nothing is hungry by then
                if (s >= n || seat_mode[s] != SEAT_EATING)
                    res.status = STATUS_BAD;
                else
                begin
                    seat_mode[s] = SEAT_THINKING;
                    // left first, then right: the right test sees the left grant
                    res.grant_mask = grant_if_clear(ring_left(s, n), n);
                    res.grant_mask = res.grant_mask | grant_if_clear(ring_right(s, n), n);
                end
            end
            REQ_END:
            begin
                if (session_over)
                    res.status = STATUS_ENDED;
                else
                begin
                    session_over = 1'b1;
                    // every hungry seat is dropped, in or out of the ring
                    for (int i = 0; i < MAX_SEATS; i++)
                    begin
                        if (seat_mode[i] == SEAT_HUNGRY)
                        begin
                            seat_mode[i]          = SEAT_THINKING;
                            res.cancelled_mask[i] = 1'b1;
                        end
                    end
                end
            end
            default:
                res.status = STATUS_BAD;
        endcase
        return res;
    endfunction

    task automatic note_field(input string field, input logic [MAX_SEATS-1:0] want,
                              input logic [MAX_SEATS-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
            mismatches++;
        end
    endtask

    // ------------------------------------------------------------------
    // Request driver: pops the backlog, holds valid until ready
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            req_ch.valid <= 1'b0;
            req_gap = 0;
        end
        else if (!req_ch.valid || req_ch.ready)
        begin
            if (req_gap > 0)
            begin
                req_gap--;
                req_ch.valid <= 1'b0;
            end
            else if (req_backlog.size() > 0)
            begin
                req_ch.req_type <= req_backlog[0].req_type;
                req_ch.seat     <= req_backlog[0].seat;
                req_ch.valid    <= 1'b1;
                void'(req_backlog.pop_front());
                if ($urandom_range(0, 31) == 0)
                    req_burst = !req_burst;
                // idle cycles inserted after this transaction is taken
                req_gap = req_burst ? 0 : $urandom_range(0, 7);
            end
            else
                req_ch.valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Monitor: tracks config writes, predicts on request acceptance,
    // checks on response acceptance, and applies response back-pressure.
    // Prediction runs before checking so a same-edge response is covered.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        rnea_result_t got;
        rnea_result_t want;
        if (!rst_n)
        begin
            foreach (seat_mode[i])
                seat_mode[i] = SEAT_THINKING;
            session_over   = 1'b0;
            seat_count_cfg = SEAT_COUNT_RESET;
            rsp_hold       = 0;
            rsp_ch.ready <= 1'b0;
        end
        else
        begin
            if (cfg_ch.valid && cfg_ch.ready)
                seat_count_cfg = cfg_ch.seat_count;

            if (req_ch.valid && req_ch.ready)
                predicted_rsp_q.push_back(arbitrate('{req_type: req_ch.req_type,
                                                       seat: req_ch.seat}));

            if (rsp_ch.valid && rsp_ch.ready)
            begin
                got.status           = rsp_ch.status;
                got.requester_eating = rsp_ch.requester_eating;
                got.grant_mask       = rsp_ch.grant_mask;
                got.cancelled_mask   = rsp_ch.cancelled_mask;
                results_seen++;
                if (predicted_rsp_q.size() == 0)
                begin
                    $display("%0t: unexpected response, expected none, actual %h",
                             $time, got);
                    mismatches++;
                end
                else
                begin
                    want = predicted_rsp_q.pop_front();
                    note_field("status", MAX_SEATS'(want.status), MAX_SEATS'(got.status));
                    note_field("requester_eating", MAX_SEATS'(want.requester_eating),
                               MAX_SEATS'(got.requester_eating));
                    note_field("grant_mask", want.grant_mask, got.grant_mask);
                    note_field("cancelled_mask", want.cancelled_mask, got.cancelled_mask);
                end
                if ($urandom_range(0, 31) == 0)
                    rsp_burst = !rsp_burst;
                rsp_hold = rsp_burst ? 0 : $urandom_range(0, 7);
            end

            // ready stays low for the drawn stall, then high until the next one
            if (rsp_hold > 0)
            begin
                rsp_hold--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any transaction on any channel resets the count
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= HANG_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic queue_item(input logic [TYPE_W-1:0] kind, input int unsigned seat_idx);
        rnea_item_t it;
        it.req_type = kind;
        it.seat     = seat_idx[SEAT_W-1:0];
        req_backlog.push_back(it);
        items_queued++;
    endtask

    // all responses back means nothing is in flight: safe for a config write
    task automatic wait_all_back();
        while (results_seen < items_queued)
            @(posedge clk);
    endtask

    task automatic write_seat_count(input logic [CNT_W-1:0] value);
        @(posedge clk);
        cfg_ch.seat_count <= value;
        cfg_ch.valid      <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
    endtask

    // first seat in the ring, from a random start, in the given mode; -1 if none
    function automatic int find_seat(input seat_mode_t mode, input int unsigned n);
        int unsigned start;
        start = $urandom_range(0, n - 1);
        for (int unsigned k = 0; k < n; k++)
            if (seat_mode[(start + k) % n] == mode)
                return (start + k) % n;
        return -1;
    endfunction

    // mostly legal traffic picked from the shadow (slightly stale, which is
    // fine), plus some noise: illegal type, any seat, any state. Never ends.
    task automatic run_random(input int unsigned count);
        int unsigned made;
        int unsigned roll;
        int unsigned n;
        int          pick;
        logic [TYPE_W-1:0] kind;
        made = 0;
        while (made < count)
        begin
            if (req_backlog.size() < 2)
            begin
                n    = ring_len();
                roll = $urandom_range(0, 99);
                if (roll < 8)
                begin
                    kind = TYPE_W'($urandom_range(0, 2));
                    if (kind == REQ_END)
                        kind = REQ_ILLEGAL;
                    queue_item(kind, $urandom_range(0, MAX_SEATS - 1));
                end
                else if (roll < 54)
                begin
                    pick = find_seat(SEAT_THINKING, n);
                    queue_item(REQ_ACQUIRE, pick < 0 ? $urandom_range(0, n - 1) : pick);
                end
                else
                begin
                    pick = find_seat(SEAT_EATING, n);
                    queue_item(REQ_RELEASE, pick < 0 ? $urandom_range(0, n - 1) : pick);
                end
                made++;
            end
            @(posedge clk);
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned ring_plan [9];

        rst_n             = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.req_type   = REQ_ACQUIRE;
        req_ch.seat       = '0;
        rsp_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.seat_count = SEAT_COUNT_RESET;
        items_queued      = 0;
        results_seen      = 0;
        mismatches        = 0;
        req_burst         = 1'b0;
        rsp_burst         = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed, reset ring of 5 seats
        queue_item(REQ_ACQUIRE, 0);      // granted at once
        queue_item(REQ_ACQUIRE, 1);      // neighbor eats: stays hungry
        queue_item(REQ_ACQUIRE, 2);      // granted
        queue_item(REQ_ACQUIRE, 4);      // wraps to seat 0, which eats
        queue_item(REQ_RELEASE, 0);      // grants seat 4 across the wrap
        queue_item(REQ_ACQUIRE, 0);      // hungry behind seat 4
        queue_item(REQ_ACQUIRE, 0);      // not thinking: bad
        queue_item(REQ_RELEASE, 1);      // hungry, not eating: bad
        queue_item(REQ_ACQUIRE, 5);      // at the count: bad
        queue_item(REQ_RELEASE, 31);     // top seat index: bad
        queue_item(REQ_ILLEGAL, 31);     // unknown type: bad
        queue_item(REQ_RELEASE, 2);      // grants seat 1
        queue_item(REQ_RELEASE, 4);      // seat 0 still blocked by seat 1
        wait_all_back();

        // random phases over several ring sizes, out-of-range values included;
        // the count changes with seats still holding state
        ring_plan = '{32, 1, 0, 2, 3, 63, 33, 17, 8};
        ring_plan[8] = $urandom_range(4, 31);
        foreach (ring_plan[p])
        begin
            write_seat_count(ring_plan[p][CNT_W-1:0]);
            run_random(PHASE_ITEMS);
            wait_all_back();
        end

        // closing: the end event freezes the block for good, so it comes last
        write_seat_count(CNT_W'(5));
        queue_item(REQ_ACQUIRE, 0);
        queue_item(REQ_ACQUIRE, 1);
        queue_item(REQ_ACQUIRE, 2);
        queue_item(REQ_ACQUIRE, 3);
        queue_item(REQ_ACQUIRE, 4);
        queue_item(REQ_END, 0);          // cancels all hungry seats
        queue_item(REQ_ACQUIRE, 2);      // after the end: ignored
        queue_item(REQ_ACQUIRE, 31);     // ended wins over a bad seat
        queue_item(REQ_END, 31);         // second end: ignored, no cancels
        queue_item(REQ_RELEASE, 0);      // releases still go through
        queue_item(REQ_RELEASE, 2);
        queue_item(REQ_RELEASE, 3);      // thinking: bad
        queue_item(REQ_ILLEGAL, 0);
        wait_all_back();

        // leave room for a stray extra response
        repeat (10) @(posedge clk);
        if (predicted_rsp_q.size() != 0)
        begin
            $display("%0t: %0d responses missing, expected %h, actual none",
                     $time, predicted_rsp_q.size(), predicted_rsp_q[0]);
            mismatches++;
        end

        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
